// ===== rtl/periodic_burst_sample_averager_macros.svh =====
// Assertion macros used by the top level of the periodic burst sample averager.
`ifndef PERIODIC_BURST_SAMPLE_AVERAGER_MACROS_SVH
`define PERIODIC_BURST_SAMPLE_AVERAGER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define PBSA_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pbsa assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define PBSA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pbsa assertion failed");

`endif

// ===== rtl/pbsa_pkg.sv =====
// Shared constants and command and status types of the periodic burst sample averager.
package pbsa_pkg;

   localparam int MAX_SAMPLES = 256;
   localparam int ADC_BITS    = 12;
   localparam int MS_PER_SEC  = 1000;
   localparam int HALF_DIV    = 2;

   localparam int TIME_W      = 32;
   localparam int COUNT_W     = 9;
   localparam int SUM_W       = 20;
   localparam int INTERVAL_W  = 16;
   localparam int READINGS_W  = 16;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam int DIVIDEND_W  = 25;
   localparam int DIVISOR_W   = 11;
   localparam int DIV_STEPS   = DIVIDEND_W;
   localparam int DIV_CNT_W   = 5;

   // Half the burst window in seconds is the window divided by 2000, taken as a shift by
   // four and a reciprocal multiply for the division by 125; it is exact below 2**24.
   localparam int BACK_SHIFT   = 4;
   localparam int BACK_DIV     = (MS_PER_SEC * HALF_DIV) / (2 ** BACK_SHIFT);
   localparam int BACK_FRAC    = 27;
   localparam int BACK_RECIP_W = 21;
   localparam int BACK_IN_W    = DIVIDEND_W - BACK_SHIFT;
   localparam int BACK_PROD_W  = BACK_IN_W + BACK_RECIP_W;
   localparam int BACK_W       = BACK_PROD_W - BACK_FRAC;
   localparam logic [BACK_RECIP_W-1:0] BACK_RECIP =
      BACK_RECIP_W'(((2 ** BACK_FRAC) + BACK_DIV - 1) / BACK_DIV);

   localparam logic [CSR_INDEX_W-1:0] REG_READING_INTERVAL = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SAMPLES_PER_READ = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SAMPLE_INTERVAL  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_BATCH_SIZE       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_START_TIME       = 3'd4;

   typedef struct packed {
      logic poll;
      logic div_start;
      logic load_back;
      logic load_out;
   } pbsa_cmd_type;

   typedef struct packed {
      logic close_due;
      logic rsp_full;
      logic div_done;
   } pbsa_status_type;

endpackage

// ===== rtl/pbsa_div.sv =====
// Restoring serial divider that produces one quotient bit per cycle.
module pbsa_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [pbsa_pkg::DIVIDEND_W-1:0]  dividend,
   input  logic [pbsa_pkg::DIVISOR_W-1:0]   divisor,
   output logic                             done,
   output logic [pbsa_pkg::DIVIDEND_W-1:0]  quotient
);
   import pbsa_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_CNT_W-1:0]  count_ff, count_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  divisor_ff, divisor_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W:0]    diff;

   always_comb begin
      shifted    = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff       = shifted - {1'b0, divisor_ff};
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      quo_in     = quo_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         rem_in     = '0;
         divisor_in = divisor;
         quo_in     = dividend;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, divisor_ff}) begin
            rem_in = diff[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         count_in = count_ff + 1'b1;
         if (count_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff   <= count_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      quo_ff     <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/pbsa_dp.sv =====
// Datapath: configuration registers, burst state, accumulation, divider and result register.
module pbsa_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [pbsa_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pbsa_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic [pbsa_pkg::TIME_W-1:0]        now_sec,
   input  logic [pbsa_pkg::TIME_W-1:0]        now_ms,
   input  logic [pbsa_pkg::ADC_BITS-1:0]      adc_sample,
   input  pbsa_pkg::pbsa_cmd_type             cmd,
   output pbsa_pkg::pbsa_status_type          status,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic [pbsa_pkg::ADC_BITS-1:0]      reading_value,
   output logic [pbsa_pkg::TIME_W-1:0]        reading_time,
   output logic                               upload_request,
   output logic [pbsa_pkg::READINGS_W-1:0]    readings_stored
);
   import pbsa_pkg::*;

   logic [TIME_W-1:0]     reading_interval_ff, reading_interval_in;
   logic [COUNT_W-1:0]    samples_per_read_ff, samples_per_read_in;
   logic [INTERVAL_W-1:0] sample_interval_ff, sample_interval_in;
   logic [READINGS_W-1:0] batch_size_ff, batch_size_in;

   logic                  burst_active_ff, burst_active_in;
   logic [TIME_W-1:0]     last_start_ff, last_start_in;
   logic [TIME_W-1:0]     last_ms_ff, last_ms_in;
   logic [COUNT_W-1:0]    sample_count_ff, sample_count_in;
   logic [SUM_W-1:0]      sample_sum_ff, sample_sum_in;
   logic [READINGS_W-1:0] reading_count_ff, reading_count_in;
   logic                  upload_ff, upload_in;

   logic [TIME_W-1:0]     sec_lat_ff, sec_lat_in;
   logic [COUNT_W-1:0]    n_lat_ff, n_lat_in;
   logic [INTERVAL_W-1:0] interval_lat_ff, interval_lat_in;
   logic [SUM_W-1:0]      sum_lat_ff, sum_lat_in;
   logic [COUNT_W-1:0]    cnt_lat_ff, cnt_lat_in;
   logic [DIVIDEND_W-1:0] window_ff, window_in;
   logic [TIME_W-1:0]     when_ff, when_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ADC_BITS-1:0]   rsp_value_ff, rsp_value_in;
   logic                  rsp_upload_ff, rsp_upload_in;
   logic [READINGS_W-1:0] rsp_readings_ff, rsp_readings_in;

   logic [COUNT_W-1:0]    n_eff;
   logic                  close_due;
   logic [TIME_W-1:0]     ms_delta;
   logic [TIME_W-1:0]     sec_delta;
   logic [READINGS_W-1:0] count_next;
   logic [DIVIDEND_W-1:0] div_dividend;
   logic [DIVISOR_W-1:0]  div_divisor;
   logic [SUM_W:0]        mean_dividend;
   logic [BACK_PROD_W-1:0] back_prod;
   logic                  div_done;
   logic [DIVIDEND_W-1:0] div_quotient;

   always_comb begin
      if (samples_per_read_ff == '0) begin
         n_eff = COUNT_W'(1);
      end else if (samples_per_read_ff > COUNT_W'(MAX_SAMPLES)) begin
         n_eff = COUNT_W'(MAX_SAMPLES);
      end else begin
         n_eff = samples_per_read_ff;
      end
   end

   assign close_due  = burst_active_ff && (sample_count_ff >= n_eff);
   assign ms_delta   = now_ms - last_ms_ff;
   assign sec_delta  = now_sec - last_start_ff;
   assign count_next = (reading_count_ff == '1) ? reading_count_ff
                                                : reading_count_ff + 1'b1;

   assign mean_dividend = {sum_lat_ff, 1'b0} + {{(SUM_W + 1 - COUNT_W){1'b0}}, cnt_lat_ff};

   assign div_dividend = {{(DIVIDEND_W - SUM_W - 1){1'b0}}, mean_dividend};
   assign div_divisor  = {{(DIVISOR_W - COUNT_W - 1){1'b0}}, cnt_lat_ff, 1'b0};

   assign back_prod = BACK_PROD_W'(window_ff[DIVIDEND_W-1:BACK_SHIFT])
                    * BACK_PROD_W'(BACK_RECIP);

   pbsa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      reading_interval_in = reading_interval_ff;
      samples_per_read_in = samples_per_read_ff;
      sample_interval_in  = sample_interval_ff;
      batch_size_in       = batch_size_ff;
      burst_active_in     = burst_active_ff;
      last_start_in       = last_start_ff;
      last_ms_in          = last_ms_ff;
      sample_count_in     = sample_count_ff;
      sample_sum_in       = sample_sum_ff;
      reading_count_in    = reading_count_ff;
      upload_in           = upload_ff;
      sec_lat_in          = sec_lat_ff;
      n_lat_in            = n_lat_ff;
      interval_lat_in     = interval_lat_ff;
      sum_lat_in          = sum_lat_ff;
      cnt_lat_in          = cnt_lat_ff;
      when_in             = when_ff;
      rsp_valid_in        = rsp_valid_ff;
      rsp_value_in        = rsp_value_ff;
      rsp_upload_in       = rsp_upload_ff;
      rsp_readings_in     = rsp_readings_ff;
      window_in           = {{(DIVIDEND_W - COUNT_W){1'b0}}, n_lat_ff}
                          * {{(DIVIDEND_W - INTERVAL_W){1'b0}}, interval_lat_ff};

      if (cmd.poll) begin
         if (close_due) begin
            sec_lat_in       = now_sec;
            n_lat_in         = n_eff;
            interval_lat_in  = sample_interval_ff;
            sum_lat_in       = sample_sum_ff;
            cnt_lat_in       = sample_count_ff;
            reading_count_in = count_next;
            rsp_readings_in  = count_next;
            rsp_upload_in    = upload_ff || (count_next >= batch_size_ff);
            upload_in        = rsp_upload_in;
            sample_sum_in    = '0;
            sample_count_in  = '0;
            burst_active_in  = 1'b0;
         end else if (burst_active_ff) begin
            if (ms_delta >= {{(TIME_W - INTERVAL_W){1'b0}}, sample_interval_ff}) begin
               sample_sum_in   = sample_sum_ff + {{(SUM_W - ADC_BITS){1'b0}}, adc_sample};
               sample_count_in = sample_count_ff + 1'b1;
               last_ms_in      = now_ms;
            end
         end else if (sec_delta >= reading_interval_ff) begin
            burst_active_in = 1'b1;
            last_start_in   = now_sec;
            sample_sum_in   = {{(SUM_W - ADC_BITS){1'b0}}, adc_sample};
            sample_count_in = COUNT_W'(1);
            last_ms_in      = now_ms;
         end
      end

      if (cmd.load_back) begin
         when_in = sec_lat_ff
                 - {{(TIME_W - BACK_W){1'b0}}, back_prod[BACK_PROD_W-1:BACK_FRAC]};
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = div_quotient[ADC_BITS-1:0];
      end

      if (csr_we) begin
         case (csr_index)
            REG_READING_INTERVAL: reading_interval_in = csr_wdata;
            REG_SAMPLES_PER_READ: samples_per_read_in = csr_wdata[COUNT_W-1:0];
            REG_SAMPLE_INTERVAL:  sample_interval_in  = csr_wdata[INTERVAL_W-1:0];
            REG_BATCH_SIZE:       batch_size_in       = csr_wdata[READINGS_W-1:0];
            REG_START_TIME:       last_start_in       = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reading_interval_ff <= TIME_W'(60);
         samples_per_read_ff <= COUNT_W'(10);
         sample_interval_ff  <= INTERVAL_W'(100);
         batch_size_ff       <= READINGS_W'(10);
         burst_active_ff     <= 1'b0;
         last_start_ff       <= '0;
         last_ms_ff          <= '0;
         sample_count_ff     <= '0;
         sample_sum_ff       <= '0;
         reading_count_ff    <= '0;
         upload_ff           <= 1'b0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         reading_interval_ff <= reading_interval_in;
         samples_per_read_ff <= samples_per_read_in;
         sample_interval_ff  <= sample_interval_in;
         batch_size_ff       <= batch_size_in;
         burst_active_ff     <= burst_active_in;
         last_start_ff       <= last_start_in;
         last_ms_ff          <= last_ms_in;
         sample_count_ff     <= sample_count_in;
         sample_sum_ff       <= sample_sum_in;
         reading_count_ff    <= reading_count_in;
         upload_ff           <= upload_in;
         rsp_valid_ff        <= rsp_valid_in;
      end
      sec_lat_ff      <= sec_lat_in;
      n_lat_ff        <= n_lat_in;
      interval_lat_ff <= interval_lat_in;
      sum_lat_ff      <= sum_lat_in;
      cnt_lat_ff      <= cnt_lat_in;
      window_ff       <= window_in;
      when_ff         <= when_in;
      rsp_value_ff    <= rsp_value_in;
      rsp_upload_ff   <= rsp_upload_in;
      rsp_readings_ff <= rsp_readings_in;
   end

   assign status.close_due = close_due;
   assign status.rsp_full  = rsp_valid_ff;
   assign status.div_done  = div_done;

   assign rsp_valid       = rsp_valid_ff;
   assign reading_value   = rsp_value_ff;
   assign reading_time    = when_ff;
   assign upload_request  = rsp_upload_ff;
   assign readings_stored = rsp_readings_ff;

endmodule

// ===== rtl/pbsa_ctrl.sv =====
// Controller state machine that sequences poll handling and the steps of a reading.
module pbsa_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  pbsa_pkg::pbsa_status_type   status,
   output pbsa_pkg::pbsa_cmd_type      cmd
);
   import pbsa_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MULT,
      ST_BACK,
      ST_MEAN_WAIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      req_tready    = 1'b0;
      cmd           = '0;
      state_in      = state_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = !(status.rsp_full && status.close_due);
            cmd.poll   = req_tvalid && req_tready;
            if (cmd.poll && status.close_due) begin
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            state_in = ST_BACK;
         end
         ST_BACK: begin
            cmd.load_back = 1'b1;
            cmd.div_start = 1'b1;
            state_in      = ST_MEAN_WAIT;
         end
         ST_MEAN_WAIT: begin
            if (status.div_done) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/periodic_burst_sample_averager.sv =====
// Top level of the periodic burst sample averager.
// A poll that does not close a burst is absorbed in one cycle, and the next poll may follow.
// A closing poll yields its reading once ST_MULT forms the burst window, ST_BACK scales it by a
// reciprocal and starts the divider, and a 25-step serial division takes the mean. Reset is
// synchronous, active high; it restores register defaults and clears burst and control state.
module periodic_burst_sample_averager (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // now_sec [31:0], now_ms [63:32], adc_sample [75:64], zero pad [79:76]
   input  logic [79:0]                         req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // reading_value [11:0], reading_time [43:12], upload_request [44],
   // readings_stored [60:45], zero pad [63:61]
   output logic [63:0]                         rsp_tdata,
   input  logic                                csr_we,
   input  logic [pbsa_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pbsa_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import pbsa_pkg::*;

   `include "periodic_burst_sample_averager_macros.svh"

   pbsa_cmd_type          cmd;
   pbsa_status_type       status;
   logic [ADC_BITS-1:0]   reading_value;
   logic [TIME_W-1:0]     reading_time;
   logic                  upload_request;
   logic [READINGS_W-1:0] readings_stored;

   pbsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pbsa_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .now_sec         (req_tdata[31:0]),
      .now_ms          (req_tdata[63:32]),
      .adc_sample      (req_tdata[75:64]),
      .cmd             (cmd),
      .status          (status),
      .rsp_ready       (rsp_tready),
      .rsp_valid       (rsp_tvalid),
      .reading_value   (reading_value),
      .reading_time    (reading_time),
      .upload_request  (upload_request),
      .readings_stored (readings_stored)
   );

   assign rsp_tdata = {3'b000, readings_stored, upload_request, reading_time, reading_value};

   `PBSA_ASSERT_SAME(a_no_close_into_full, req_tready && status.rsp_full, !status.close_due)
   `PBSA_ASSERT_SAME(a_no_result_overwrite, cmd.load_out, !status.rsp_full)
   `PBSA_ASSERT_NEXT(a_busy_after_close, cmd.poll && status.close_due, !req_tready)

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the periodic burst sample averager: directed table, then random phases.
module tb_top;
   import pbsa_pkg::*;

   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 6;
   localparam int IDLE_PCT      = 18;
   localparam int SETTLE_CYCLES = 64;
   localparam int HOLD_CYCLES   = 500;
   localparam int STALL_LIMIT   = 3000;
   localparam int PHASES        = 10;

   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_LO = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [15:0] stored;
      logic        upload;
      logic [31:0] when;
      logic [11:0] value;
   } reading_type;

   typedef struct {
      bit                     is_csr;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  wdata;
      logic [31:0]            sec;
      logic [31:0]            ms;
      logic [11:0]            adc;
      bit                     typed;
      reading_type            want;
   } step_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [79:0]            req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [63:0]            rsp_tdata;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   logic [31:0] cfg_interval_sec;
   logic [8:0]  cfg_samples;
   logic [15:0] cfg_sample_ms;
   logic [15:0] cfg_batch;
   logic [31:0] cfg_start_sec;

   bit          burst_on;
   logic [31:0] burst_start_sec;
   logic [31:0] last_sample_ms;
   logic [8:0]  held_count;
   logic [19:0] held_sum;
   logic [15:0] reading_total;
   bit          upload_flag;

   reading_type  readings_due[$];
   step_row_type directed_steps[$];
   reading_type  seen_reading;
   reading_type  due_reading;
   int          mismatches = 0;
   int          stall_cycles = 0;
   bit          quiet = 1'b0;
   bit          hold_go = 1'b0;

   periodic_burst_sample_averager uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #(HALF_PERIOD) clock = ~clock;
   end

   function automatic void add_step(input step_row_type row);
      directed_steps = {directed_steps, row};
   endfunction

   function automatic void add_due(input reading_type r);
      readings_due = {readings_due, r};
   endfunction

   function automatic logic [8:0] burst_length();
      logic [8:0] n;
      n = cfg_samples;
      if (n == 0) n = 9'd1;
      if (n > MAX_SAMPLES) n = 9'(MAX_SAMPLES);
      return n;
   endfunction

   task automatic average_poll(input logic [31:0] sec, input logic [31:0] ms,
                               input logic [11:0] adc, output bit closed,
                               output reading_type r);
      logic [8:0]  n;
      logic [31:0] mean;
      logic [31:0] window;
      n = burst_length();
      closed = 1'b0;
      r = '0;
      if (burst_on) begin
         if (held_count >= n) begin
            mean = (2 * 32'(held_sum) + 32'(held_count)) / (2 * 32'(held_count));
            window = 32'(n) * 32'(cfg_sample_ms);
            if (reading_total != 16'hFFFF) reading_total++;
            if (reading_total >= cfg_batch) upload_flag = 1'b1;
            held_sum = '0;
            held_count = '0;
            burst_on = 1'b0;
            closed = 1'b1;
            r.value = mean[11:0];
            r.when = sec - (window / MS_PER_SEC) / HALF_DIV;
            r.upload = upload_flag;
            r.stored = reading_total;
         end else if (ms - last_sample_ms >= 32'(cfg_sample_ms)) begin
            held_sum += adc;
            held_count++;
            last_sample_ms = ms;
         end
      end else if (sec - burst_start_sec >= cfg_interval_sec) begin
         burst_on = 1'b1;
         burst_start_sec = sec;
         held_sum = 20'(adc);
         held_count = 9'd1;
         last_sample_ms = ms;
      end
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      case (index)
         REG_READING_INTERVAL: cfg_interval_sec = data;
         REG_SAMPLES_PER_READ: cfg_samples = data[8:0];
         REG_SAMPLE_INTERVAL: cfg_sample_ms = data[15:0];
         REG_BATCH_SIZE: cfg_batch = data[15:0];
         REG_START_TIME: begin
            cfg_start_sec = data;
            burst_start_sec = data;
         end
         default: ;
      endcase
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (readings_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic send_poll(input logic [31:0] sec, input logic [31:0] ms,
                            input logic [11:0] adc, input bit typed, input reading_type want);
      bit          closed;
      reading_type r;
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0, adc, ms, sec};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      average_poll(sec, ms, adc, closed, r);
      if (typed) add_due(want);
      else if (closed) add_due(r);
      @(negedge clock);
   endtask

   // Most polls are aimed at, just past or just short of the next burst start or sample time.
   task automatic random_poll();
      logic [31:0] sec;
      logic [31:0] ms;
      logic [11:0] adc;
      int          roll;
      int          slack;
      int          pick;
      roll = $urandom_range(99);
      sec = $urandom;
      ms = $urandom;
      if (roll >= 8) begin
         if (!burst_on) begin
            slack = (cfg_interval_sec > 32'hFFFF_FF00) ? 0 : $urandom_range(3);
            sec = burst_start_sec + cfg_interval_sec + slack;
            if (roll < 16) sec = sec - slack - 1;
         end else begin
            sec = burst_start_sec + $urandom_range(40);
            ms = last_sample_ms + cfg_sample_ms + $urandom_range(2);
            if (roll < 16) ms = last_sample_ms + cfg_sample_ms - 1;
         end
      end
      pick = $urandom_range(9);
      adc = (pick == 0) ? 12'h000 : (pick == 1) ? 12'hFFF : 12'($urandom_range(4095));
      send_poll(sec, ms, adc, 1'b0, '0);
   endtask

   function automatic step_row_type csr_row(input logic [CSR_INDEX_W-1:0] index,
                                            input logic [CSR_DATA_W-1:0] data);
      step_row_type row;
      row.is_csr = 1'b1;
      row.index = index;
      row.wdata = data;
      row.sec = '0;
      row.ms = '0;
      row.adc = '0;
      row.typed = 1'b0;
      row.want = '0;
      return row;
   endfunction

   function automatic step_row_type poll_row(input logic [31:0] sec, input logic [31:0] ms,
                                             input logic [11:0] adc);
      step_row_type row;
      row = csr_row('0, '0);
      row.is_csr = 1'b0;
      row.sec = sec;
      row.ms = ms;
      row.adc = adc;
      return row;
   endfunction

   function automatic step_row_type checked_row(input logic [31:0] sec, input logic [31:0] ms,
                                                input logic [11:0] adc, input logic [11:0] value,
                                                input logic [31:0] when, input logic upload,
                                                input logic [15:0] stored);
      step_row_type row;
      row = poll_row(sec, ms, adc);
      row.typed = 1'b1;
      row.want = '{stored: stored, upload: upload, when: when, value: value};
      return row;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_reading = rsp_tdata[60:0];
         if (readings_due.size() == 0) begin
            mismatches++;
            $display("%0t unexpected transfer: expected none, actual %0h", $time, rsp_tdata);
         end else begin
            due_reading = readings_due.pop_front();
            check_field("reading_value", due_reading.value, seen_reading.value);
            check_field("reading_time", due_reading.when, seen_reading.when);
            check_field("upload_request", due_reading.upload, seen_reading.upload);
            check_field("readings_stored", due_reading.stored, seen_reading.stored);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int held;
      forever begin
         @(negedge clock);
         if (hold_go) begin
            hold_go <= 1'b0;
            rsp_tready <= 1'b0;
            for (held = 1; held < HOLD_CYCLES; held++) @(negedge clock);
         end else begin
            rsp_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   initial begin
      int           phase;
      int           span;
      int           pick;
      int           k;
      logic [31:0]  iv;
      logic [31:0]  sp;
      logic [31:0]  sm;
      logic [31:0]  bs;
      step_row_type row;

      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      cfg_interval_sec = 32'd60;
      cfg_samples = 9'd10;
      cfg_sample_ms = 16'd100;
      cfg_batch = 16'd10;
      cfg_start_sec = '0;
      burst_on = 1'b0;
      burst_start_sec = '0;
      last_sample_ms = '0;
      held_count = '0;
      held_sum = '0;
      reading_total = '0;
      upload_flag = 1'b0;

      // A zero sample count behaves as one sample per reading.
      add_step(csr_row(REG_SAMPLES_PER_READ, 32'd0));
      add_step(csr_row(REG_SAMPLE_INTERVAL, 32'd0));
      add_step(poll_row(32'd59, 32'd0, 12'h000));
      add_step(poll_row(32'd60, 32'd5, 12'hFFF));
      add_step(checked_row(32'd61, 32'd6, 12'h000, 12'hFFF, 32'd61, 1'b0, 16'd1));
      add_step(poll_row(32'd120, 32'd0, 12'h000));
      add_step(checked_row(32'd0, 32'd0, 12'h001, 12'h000, 32'd0, 1'b0, 16'd2));
      add_step(csr_row(REG_SAMPLES_PER_READ, 32'd2));
      add_step(csr_row(REG_SAMPLE_INTERVAL, 32'd1000));
      add_step(poll_row(32'd180, 32'd100, 12'h001));
      add_step(poll_row(32'd181, 32'd1099, 12'hFA0));
      add_step(poll_row(32'd181, 32'd1100, 12'h002));
      add_step(checked_row(32'd200, 32'd0, 12'h007, 12'd2, 32'd199, 1'b0, 16'd3));
      add_step(poll_row(32'd260, 32'hFFFF_FF00, 12'd10));
      add_step(poll_row(32'd261, 32'h0000_02E8, 12'd11));
      add_step(checked_row(32'd5, 32'd0, 12'h000, 12'd11, 32'd4, 1'b0, 16'd4));
      add_step(csr_row(REG_START_TIME, 32'hFFFF_FFF0));
      add_step(csr_row(REG_SPARE_LO, 32'hFFFF_FFFF));
      add_step(csr_row(REG_SPARE_HI, 32'd0));
      add_step(poll_row(32'h0000_002B, 32'd0, 12'h000));
      add_step(poll_row(32'h0000_002C, 32'hFFFF_FFFF, 12'hFFF));
      add_step(poll_row(32'h0000_002C, 32'd999, 12'hFFF));
      add_step(checked_row(32'hFFFF_FFFF, 32'd0, 12'h000, 12'hFFF,
                           32'hFFFF_FFFE, 1'b0, 16'd5));
      add_step(csr_row(REG_BATCH_SIZE, 32'd0));
      add_step(csr_row(REG_READING_INTERVAL, 32'd0));
      add_step(csr_row(REG_SAMPLES_PER_READ, 32'd1));
      add_step(csr_row(REG_SAMPLE_INTERVAL, 32'd65535));
      add_step(poll_row(32'h1234_5678, 32'd0, 12'd100));
      add_step(checked_row(32'h1234_5678, 32'd0, 12'h000, 12'd100,
                           32'h1234_5658, 1'b1, 16'd6));
      add_step(csr_row(REG_READING_INTERVAL, 32'hFFFF_FFFF));
      add_step(poll_row(32'h1234_5677, 32'd0, 12'h000));
      add_step(checked_row(32'd0, 32'hFFFF_FFFF, 12'hFFF, 12'h000,
                           32'hFFFF_FFE0, 1'b1, 16'd7));
      add_step(poll_row(32'h1234_5677, 32'd0, 12'd5));
      add_step(poll_row(32'h1234_5676, 32'd0, 12'd5));
      add_step(poll_row(32'h1234_5676, 32'd0, 12'd5));

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (k = 0; k < directed_steps.size(); k++) begin
         row = directed_steps[k];
         if (row.is_csr) begin
            settle();
            write_csr(row.index, row.wdata);
         end else begin
            send_poll(row.sec, row.ms, row.adc, row.typed, row.want);
         end
      end

      for (phase = 0; phase < PHASES; phase++) begin
         settle();
         case (phase)
            0: begin
               iv = 0; sp = 1; sm = 0; bs = 1; span = 200;
            end
            1: begin
               iv = $urandom_range(1, 5); sp = $urandom_range(2, 8);
               sm = $urandom_range(50); bs = 65535; span = 200;
            end
            2: begin
               iv = 32'hFFFF_FFFF; sp = 256; sm = 65535; bs = 0; span = 400;
            end
            3: begin
               iv = $urandom_range(3); sp = $urandom_range(1, 4);
               sm = $urandom_range(10); bs = $urandom_range(65535); span = 150;
            end
            4: begin
               iv = $urandom; sp = $urandom_range(257, 511);
               sm = $urandom_range(65535); bs = $urandom_range(65535); span = 300;
            end
            5: begin
               iv = 0; sp = 0; sm = 65535; bs = 65535; span = 150;
            end
            default: begin
               pick = $urandom_range(2);
               iv = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(1, 10) : $urandom;
               sp = $urandom_range(12);
               sm = $urandom_range(1) ? $urandom_range(200) : $urandom_range(65535);
               bs = $urandom_range(20);
               span = 150;
            end
         endcase
         write_csr(REG_READING_INTERVAL, iv);
         write_csr(REG_SAMPLES_PER_READ, sp);
         write_csr(REG_SAMPLE_INTERVAL, sm);
         write_csr(REG_BATCH_SIZE, bs);
         write_csr(REG_START_TIME, $urandom);
         quiet <= (phase == 1);
         if (phase == 0) hold_go <= 1'b1;
         for (k = 0; k < span; k++) random_poll();
      end

      settle();
      if (mismatches == 0 && readings_due.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/pbsa_pkg.sv
rtl/pbsa_div.sv
rtl/pbsa_dp.sv
rtl/pbsa_ctrl.sv
rtl/periodic_burst_sample_averager.sv
bench/tb_top.sv
